>>> sv/reduced_fraction_alu_unit_macros.svh
// Assertion helpers for the reduced fraction ALU.
`ifndef REDUCED_FRACTION_ALU_UNIT_MACROS_SVH
`define REDUCED_FRACTION_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RFA_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rfa_pkg.sv
package rfa_pkg;

    localparam int OPERAND_W = 16;  // operand field width
    localparam int PROD_W    = 64;  // products are sign-extended to this width
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 32;
    localparam int SHIFT_W   = $clog2(PROD_W);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                        command;
        logic signed [OPERAND_W-1:0] a_num;
        logic signed [OPERAND_W-1:0] a_den;
        logic signed [OPERAND_W-1:0] b_num;
        logic signed [OPERAND_W-1:0] b_den;
    } in_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_num;
        logic signed [DEN_W-1:0] result_den;
        logic                    zero_den_error;
    } out_word_t;

endpackage

>>> sv/reduced_fraction_alu_unit.sv
// Channel   | Signals                  | Word          | Handshake
// ----------+--------------------------+---------------+-------------------------------
// operands  | start, busy, operands    | in_word_t     | taken when start && !busy
// result    | done, result             | out_word_t    | valid for the one cycle done=1
//
// Steps: the products on the shared multiplier (three for add and subtract, two for multiply
// and divide), a check, a binary GCD (one shift or one 64-bit compare-and-subtract per
// cycle), then two bit-serial restoring divisions by the GCD. Zero results and zero
// denominators skip GCD and divide.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with no strobe.
// busy is high from the edge that takes a word until done pulses; the receiver cannot stall.

`include "reduced_fraction_alu_unit_macros.svh"

module reduced_fraction_alu_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rfa_pkg::in_word_t operands,
    output logic              done,
    output rfa_pkg::out_word_t result
);

    localparam int W     = rfa_pkg::OPERAND_W;
    localparam int PW    = rfa_pkg::PROD_W;
    localparam int NW    = rfa_pkg::NUM_W;
    localparam int DW    = rfa_pkg::DEN_W;
    localparam int SW    = rfa_pkg::SHIFT_W;

    // Sequencer states. MUL0..MUL2 share one signed multiplier; GCD and
    // the divider each take one compare-and-subtract step per cycle.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_CHECK,
        S_GCD,
        S_DIV_NUM,
        S_DIV_DEN
    } state_t;

    state_t              state_reg, state_next;
    rfa_pkg::in_word_t   op_reg, op_next;
    logic [PW-1:0]       num_reg, num_next;     // signed product, later magnitude
    logic [PW-1:0]       den_reg, den_next;
    logic [PW-1:0]       tmp_reg, tmp_next;     // second cross product
    logic                num_neg_reg, num_neg_next;
    logic                den_neg_reg, den_neg_next;
    logic [PW-1:0]       x_reg, x_next;         // GCD working pair
    logic [PW-1:0]       y_reg, y_next;
    logic [SW-1:0]       k_reg, k_next;         // shared power of two
    logic [PW-1:0]       divisor_reg, divisor_next;
    logic [PW:0]         rem_reg, rem_next;
    logic [PW-1:0]       quo_reg, quo_next;     // dividend shifts out, quotient in
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       qn_reg, qn_next;
    logic                done_reg, done_next;
    rfa_pkg::out_word_t  result_reg, result_next;

    // Shared multiplier
    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [2*W-1:0] prod_full;
    logic [PW-1:0]         prod;

    // Datapath helpers
    logic [PW-1:0] num_mag, den_mag;
    logic          x_eq_y, x_gt_y;
    logic [PW-1:0] x_minus_y, y_minus_x;
    logic [PW:0]   rem_sh, rem_sub;
    logic          rem_fit;
    logic [PW-1:0] quo_shift;
    logic [NW-1:0] qn_raw;
    logic [DW-1:0] qd_raw, qd_signed;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    // Operand selection for the one multiplier
    always_comb
    begin
        mul_a = op_reg.a_num;
        mul_b = op_reg.b_den;
        unique case (state_reg)
            S_MUL0:
            begin
                mul_a = op_reg.a_num;
                mul_b = (op_reg.command == rfa_pkg::CMD_MUL) ? op_reg.b_num : op_reg.b_den;
            end
            S_MUL1:
            begin
                if (op_reg.command == rfa_pkg::CMD_MUL)
                begin
                    mul_a = op_reg.a_den;
                    mul_b = op_reg.b_den;
                end
                else
                begin
                    mul_a = op_reg.b_num;
                    mul_b = op_reg.a_den;
                end
            end
            S_MUL2:
            begin
                mul_a = op_reg.a_den;
                mul_b = op_reg.b_den;
            end
            default:
            begin
                mul_a = op_reg.a_num;
                mul_b = op_reg.b_den;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod      = PW'(prod_full);

    assign num_mag = num_reg[PW-1] ? (~num_reg + PW'(1)) : num_reg;
    assign den_mag = den_reg[PW-1] ? (~den_reg + PW'(1)) : den_reg;

    assign x_eq_y    = (x_reg == y_reg);
    assign x_gt_y    = (x_reg > y_reg);
    assign x_minus_y = x_reg - y_reg;
    assign y_minus_x = y_reg - x_reg;

    // One restoring-division step
    assign rem_sh    = {rem_reg[PW-1:0], quo_reg[PW-1]};
    assign rem_fit   = (rem_sh >= {1'b0, divisor_reg});
    assign rem_sub   = rem_sh - {1'b0, divisor_reg};
    assign quo_shift = {quo_reg[PW-2:0], rem_fit};

    assign qn_raw    = num_neg_reg ? (~qn_reg + NW'(1)) : qn_reg;
    assign qd_raw    = quo_shift[DW-1:0];
    assign qd_signed = den_neg_reg ? (~qd_raw + DW'(1)) : qd_raw;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        tmp_next     = tmp_reg;
        num_neg_next = num_neg_reg;
        den_neg_next = den_neg_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        k_next       = k_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        qn_next      = qn_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operands;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                num_next   = prod;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                if (op_reg.command == rfa_pkg::CMD_ADD || op_reg.command == rfa_pkg::CMD_SUB)
                begin
                    tmp_next   = prod;
                    state_next = S_MUL2;
                end
                else
                begin
                    den_next   = prod;
                    state_next = S_CHECK;
                end
            end
            S_MUL2:
            begin
                den_next   = prod;
                num_next   = (op_reg.command == rfa_pkg::CMD_SUB) ? (num_reg - tmp_reg)
                                                                   : (num_reg + tmp_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (den_reg == '0)
                begin
                    result_next.result_num     = '0;
                    result_next.result_den     = '0;
                    result_next.zero_den_error = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (num_reg == '0)
                begin
                    result_next.result_num     = '0;
                    result_next.result_den     = DW'(1);
                    result_next.zero_den_error = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    num_neg_next = num_reg[PW-1];
                    den_neg_next = den_reg[PW-1];
                    num_next     = num_mag;
                    den_next     = den_mag;
                    x_next       = num_mag;
                    y_next       = den_mag;
                    k_next       = '0;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                // Both stay nonzero; equal means x shifted left by k is the GCD.
                priority if (x_eq_y)
                begin
                    divisor_next = x_reg << k_reg;
                    quo_next     = num_reg;
                    rem_next     = '0;
                    cnt_next     = '0;
                    state_next   = S_DIV_NUM;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + SW'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_gt_y)
                begin
                    x_next = x_minus_y;
                end
                else
                begin
                    y_next = y_minus_x;
                end
            end
            S_DIV_NUM:
            begin
                rem_next = rem_fit ? rem_sub : rem_sh;
                quo_next = quo_shift;
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(PW - 1))
                begin
                    qn_next    = quo_shift[NW-1:0];
                    quo_next   = den_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV_DEN;
                end
            end
            S_DIV_DEN:
            begin
                rem_next = rem_fit ? rem_sub : rem_sh;
                quo_next = quo_shift;
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(PW - 1))
                begin
                    result_next.result_num     = qn_raw;
                    result_next.result_den     = qd_signed;
                    result_next.zero_den_error = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        tmp_reg     <= tmp_next;
        num_neg_reg <= num_neg_next;
        den_neg_reg <= den_neg_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        qn_reg      <= qn_next;
    end

    // Checks
    `RFA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "done while busy")
    `RFA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted word not busy")
    `RFA_ASSERT_NOW(a_err_zero, clk, rst_n, done && result.zero_den_error, result.result_num == '0 && result.result_den == '0, "error result not zero")
    `RFA_ASSERT_NOW(a_den_nonzero, clk, rst_n, done && !result.zero_den_error, result.result_den != '0, "zero denominator without error")

endmodule
